// ----- rtl/alnis_pkg.sv -----
// Shared types, codes and widths of the arc-length index search block.
package alnis_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 10;
    localparam int POS_W      = 32;
    localparam int OUT_W      = 10;
    localparam int PC_W       = 11;
    localparam int TOL_W      = 16;
    localparam int OPND_W     = POS_W + 2;
    localparam int SUM_W      = OPND_W + 1;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_LOWER   = 2'd1;
    localparam logic [OP_W-1:0] OP_NEAREST = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_TOL     = 2'd1;

    localparam logic [PC_W-1:0]  POINT_COUNT_RST = 11'd1;
    localparam logic [TOL_W-1:0] END_TOL_RST     = 16'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NR_LO,
        ST_NR_HI,
        ST_NR_TOP,
        ST_BS_ADDR,
        ST_BS_DATA,
        ST_NB_A,
        ST_NB_B,
        ST_NB_C,
        ST_NB_D,
        ST_RESULT
    } alnis_state_t;

    typedef struct packed {
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
        logic signed [OPND_W-1:0] c;
    } alnis_alu_req_t;

    typedef struct packed {
        logic              neg;
        logic [OPND_W-1:0] mag;
    } alnis_alu_rsp_t;

endpackage

// ----- rtl/alnis_mem.sv -----
// Arc-length table memory with one write port and one registered read port.
module alnis_mem
    import alnis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [POS_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [POS_W-1:0] rd_data
);

    logic [POS_W-1:0] mem [TABLE_DEPTH];
    logic [POS_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/alnis_alu.sv -----
// Shared add, compare and magnitude unit used by the end checks, the binary search and the neighbor compare.
module alnis_alu
    import alnis_pkg::*;
(
    input  alnis_alu_req_t req,
    output alnis_alu_rsp_t rsp
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] alt;

    always_comb begin
        sum = SUM_W'(req.a) - SUM_W'(req.b) + SUM_W'(req.c);
        alt = SUM_W'(req.b) - SUM_W'(req.a) - SUM_W'(req.c);
        rsp.neg = sum[SUM_W-1];
        rsp.mag = sum[SUM_W-1] ? alt[OPND_W-1:0] : sum[OPND_W-1:0];
    end

endmodule

// ----- rtl/alnis_seq.sv -----
// Sequencer that takes table writes and runs the end checks, the binary search and the neighbor compare.
module alnis_seq
    import alnis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [OP_W-1:0]   op,
    input  logic [SLOT_W-1:0] slot,
    input  logic [POS_W-1:0]  pos,
    input  logic [PC_W-1:0]   point_count,
    input  logic [TOL_W-1:0]  end_tol,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    input  logic [POS_W-1:0]  rd_data,
    output alnis_alu_req_t    alu_req,
    input  alnis_alu_rsp_t    alu_rsp,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  point_index
);

    alnis_state_t state_reg, state_next;

    logic signed [OPND_W-1:0] pos_reg, pos_next;
    logic                     nearest_reg, nearest_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         res_reg, res_next;
    logic [OPND_W-1:0]        dist_lo_reg, dist_lo_next;
    logic [OPND_W-1:0]        dist_hi_reg, dist_hi_next;
    logic                     m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]         m_idx_reg, m_idx_next;

    logic [CNT_W:0]           lh_sum;
    logic [CNT_W-1:0]         mid;
    logic [CNT_W-1:0]         mid_p1;
    logic [CNT_W-1:0]         n_m1;
    logic [CNT_W-1:0]         lo_m1;
    logic [CNT_W-1:0]         n_clamped;
    logic signed [OPND_W-1:0] rd_ext;
    logic signed [OPND_W-1:0] tol_ext;
    logic                     out_free;

    always_comb begin
        lh_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = lh_sum[CNT_W:1];
        mid_p1  = mid + 1'b1;
        n_m1    = n_reg - 1'b1;
        lo_m1   = lo_reg - 1'b1;
        rd_ext  = {{(OPND_W - POS_W){rd_data[POS_W-1]}}, rd_data};
        tol_ext = $signed({{(OPND_W - TOL_W){1'b0}}, end_tol});
        out_free = !m_valid_reg || m_tready;
        if (point_count == '0) begin
            n_clamped = CNT_W'(1);
        end else if (32'(point_count) > 32'(TABLE_DEPTH)) begin
            n_clamped = CNT_W'(TABLE_DEPTH);
        end else begin
            n_clamped = CNT_W'(point_count);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && op == OP_LOWER) begin
                    state_next = ST_BS_ADDR;
                end else if (s_tvalid && op == OP_NEAREST) begin
                    state_next = ST_NR_LO;
                end
            end
            ST_NR_LO:  state_next = ST_NR_HI;
            ST_NR_HI:  state_next = alu_rsp.neg ? ST_RESULT : ST_NR_TOP;
            ST_NR_TOP: state_next = alu_rsp.neg ? ST_RESULT : ST_BS_ADDR;
            ST_BS_ADDR: begin
                priority if (lo_reg < hi_reg) begin
                    state_next = ST_BS_DATA;
                end else if (lo_reg == n_reg) begin
                    state_next = ST_RESULT;
                end else if (nearest_reg && lo_reg != '0) begin
                    state_next = ST_NB_A;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_BS_DATA: state_next = ST_BS_ADDR;
            ST_NB_A:    state_next = ST_NB_B;
            ST_NB_B:    state_next = ST_NB_C;
            ST_NB_C:    state_next = ST_NB_D;
            ST_NB_D:    state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pos_next     = pos_reg;
        nearest_next = nearest_reg;
        n_next       = n_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        res_next     = res_reg;
        dist_lo_next = dist_lo_reg;
        dist_hi_next = dist_hi_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_idx_next   = m_idx_reg;
        wr_en        = 1'b0;
        wr_addr      = IDX_W'(slot);
        rd_en        = 1'b0;
        rd_addr      = '0;
        alu_req      = '{a: pos_reg, b: rd_ext, c: '0};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    wr_en = (op == OP_WRITE) && (32'(slot) < 32'(TABLE_DEPTH));
                    pos_next     = {{(OPND_W - POS_W){pos[POS_W-1]}}, pos};
                    nearest_next = (op == OP_NEAREST);
                    n_next       = n_clamped;
                    lo_next      = '0;
                    hi_next      = n_clamped;
                end
            end
            ST_NR_LO: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_NR_HI: begin
                rd_en   = 1'b1;
                rd_addr = n_m1[IDX_W-1:0];
                alu_req = '{a: pos_reg, b: rd_ext, c: tol_ext};
                if (alu_rsp.neg) begin
                    res_next = '0;
                end
            end
            ST_NR_TOP: begin
                alu_req = '{a: rd_ext, b: pos_reg, c: tol_ext};
                if (alu_rsp.neg) begin
                    res_next = n_m1[IDX_W-1:0];
                end
            end
            ST_BS_ADDR: begin
                if (lo_reg < hi_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = mid[IDX_W-1:0];
                end else if (lo_reg == n_reg) begin
                    res_next = n_m1[IDX_W-1:0];
                end else begin
                    res_next = lo_reg[IDX_W-1:0];
                end
            end
            ST_BS_DATA: begin
                alu_req = '{a: rd_ext, b: pos_reg, c: '0};
                if (alu_rsp.neg) begin
                    lo_next = mid_p1;
                end else begin
                    hi_next = mid;
                end
            end
            ST_NB_A: begin
                rd_en   = 1'b1;
                rd_addr = lo_m1[IDX_W-1:0];
            end
            ST_NB_B: begin
                rd_en        = 1'b1;
                rd_addr      = lo_reg[IDX_W-1:0];
                alu_req      = '{a: rd_ext, b: pos_reg, c: '0};
                dist_lo_next = alu_rsp.mag;
            end
            ST_NB_C: begin
                alu_req      = '{a: rd_ext, b: pos_reg, c: '0};
                dist_hi_next = alu_rsp.mag;
            end
            ST_NB_D: begin
                alu_req  = '{a: $signed(dist_lo_reg), b: $signed(dist_hi_reg), c: '0};
                res_next = alu_rsp.neg ? lo_m1[IDX_W-1:0] : lo_reg[IDX_W-1:0];
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        nearest_reg <= nearest_next;
        n_reg       <= n_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        res_reg     <= res_next;
        dist_lo_reg <= dist_lo_next;
        dist_hi_reg <= dist_hi_next;
        m_idx_reg   <= m_idx_next;
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_valid_reg;
    assign point_index = OUT_W'(m_idx_reg);

endmodule

// ----- rtl/arc_length_nearest_index_search.sv -----
// Top level of the arc-length index search: configuration registers, table and sequencer.
//
// A write word stores one table entry. A lower-bound query runs a binary search over the
// n entries in use; a nearest query adds the two end checks and the neighbor compare.
// The search is paced by the single table read port, whose data is registered: every
// probe of the binary search reads the table in ST_BS_ADDR and compares in ST_BS_DATA,
// using the shared add and compare unit. The input side is not ready while a query runs,
// and a finished result waits in an output register so the next word can be taken. The
// table holds no valid bits and must be written before it is read.
module arc_length_nearest_index_search
    import alnis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // entry_index[9:0], position[41:10]
    input  logic [OP_W-1:0]       s_tuser,   // operation[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // point_index[9:0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [PC_W-1:0]  point_count_reg, point_count_next;
    logic [TOL_W-1:0] end_tol_reg, end_tol_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [POS_W-1:0] rd_data;
    logic [OUT_W-1:0] point_index;
    alnis_alu_req_t   alu_req;
    alnis_alu_rsp_t   alu_rsp;

    assign cfg_ready = 1'b1;

    always_comb begin
        point_count_next = point_count_reg;
        end_tol_next     = end_tol_reg;
        if (cfg_valid) begin
            if (cfg_addr == CFG_POINT_COUNT) begin
                point_count_next = cfg_data[PC_W-1:0];
            end else if (cfg_addr == CFG_END_TOL) begin
                end_tol_next = cfg_data[TOL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RST;
            end_tol_reg     <= END_TOL_RST;
        end else begin
            point_count_reg <= point_count_next;
            end_tol_reg     <= end_tol_next;
        end
    end

    alnis_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[SLOT_W +: POS_W]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    alnis_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    alnis_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .op          (s_tuser),
        .slot        (s_tdata[SLOT_W-1:0]),
        .pos         (s_tdata[SLOT_W +: POS_W]),
        .point_count (point_count_reg),
        .end_tol     (end_tol_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .point_index (point_index)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, point_index};

endmodule

// ----- test/tb_arc_length_nearest_index_search.sv -----
// Self-checking testbench for the arc-length index search: directed table, then random phases.
module tb_arc_length_nearest_index_search;
    import alnis_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int ITEM_TARGET = 950;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;

    localparam logic [OP_W-1:0]       OP_SPARE    = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        bit                    is_reg;
        logic [OP_W-1:0]       code;
        logic [SLOT_W-1:0]     slot;
        logic [POS_W-1:0]      value;
        bit                    typed;
        logic [OUT_W-1:0]      index;
    } step_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic signed [POS_W-1:0] arc_len [DEPTH];
    bit                      written [DEPTH];
    logic [PC_W-1:0]         count_reg = POINT_COUNT_RST;
    logic [TOL_W-1:0]        tol_reg   = END_TOL_RST;
    logic [OUT_W-1:0]        expected_index [$];
    step_t                   plan [$];

    int fails       = 0;
    int sent        = 0;
    int quiet       = 0;
    int tx_idle_pct = 10;
    int rx_idle_pct = 52;
    bit hold_pending = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    arc_length_nearest_index_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    function automatic step_t word_row(logic [OP_W-1:0] op, int slot, logic [POS_W-1:0] pos,
                                       bit typed = 1'b0, int index = 0);
        step_t r;
        r.is_reg = 1'b0;
        r.code   = op;
        r.slot   = SLOT_W'(slot);
        r.value  = pos;
        r.typed  = typed;
        r.index  = OUT_W'(index);
        return r;
    endfunction

    function automatic step_t reg_row(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        step_t r;
        r = word_row(OP_WRITE, 0, POS_W'(data));
        r.is_reg = 1'b1;
        r.code   = addr;
        return r;
    endfunction

    function automatic int unsigned used_count();
        int unsigned n;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    function automatic logic [OUT_W-1:0] predict_index(logic [OP_W-1:0] op,
                                                       logic signed [POS_W-1:0] p);
        int unsigned n, lo, hi, mid, idx;
        longint pos, tol, below, above;
        n   = used_count();
        pos = p;
        tol = tol_reg;
        lo  = 0;
        hi  = n;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (longint'(arc_len[mid]) < pos) lo = mid + 1;
            else hi = mid;
        end
        idx = (lo >= n) ? n - 1 : lo;
        if (op == OP_NEAREST) begin
            if (pos < longint'(arc_len[0]) - tol) begin
                idx = 0;
            end else if (pos > longint'(arc_len[n-1]) + tol) begin
                idx = n - 1;
            end else if (lo > 0 && lo < n) begin
                below = longint'(arc_len[lo-1]) - pos;
                above = longint'(arc_len[lo]) - pos;
                if (below < 0) below = -below;
                if (above < 0) above = -above;
                if (below < above) idx = lo - 1;
            end
        end
        return OUT_W'(idx);
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int unsigned n);
        longint v;
        int unsigned k;
        k = $urandom_range(n - 1);
        case ($urandom_range(19))
            0: v = POS_MIN;
            1: v = POS_MAX;
            2, 3: v = longint'($signed($urandom));
            4, 5, 6: v = longint'(arc_len[0]) - longint'(tol_reg)
                         + longint'($urandom_range(4)) - 2;
            7, 8, 9: v = longint'(arc_len[n-1]) + longint'(tol_reg)
                         + longint'($urandom_range(4)) - 2;
            10, 11, 12: begin
                if (k == 0) k = 1;
                if (k >= n) k = n - 1;
                if (k == 0) begin
                    v = longint'(arc_len[0]) + longint'($urandom_range(2)) - 1;
                end else begin
                    v = (longint'(arc_len[k-1]) + longint'(arc_len[k])) / 2
                        + longint'($urandom_range(2)) - 1;
                end
            end
            default: v = longint'(arc_len[k]) + longint'($urandom_range(6)) - 3;
        endcase
        if (v > longint'(POS_MAX)) v = POS_MAX;
        if (v < longint'(POS_MIN)) v = POS_MIN;
        return POS_W'(v);
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                             logic signed [POS_W-1:0] pos, bit typed = 1'b0,
                             logic [OUT_W-1:0] index = '0);
        if (sent < ITEM_TARGET / 3) begin
            tx_idle_pct = 10;
            rx_idle_pct = 52;
        end else if (sent < 2 * ITEM_TARGET / 3) begin
            tx_idle_pct = 52;
            rx_idle_pct = 10;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - POS_W - SLOT_W){1'b0}}, pos, slot};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_WRITE) begin
            arc_len[slot] = pos;
            written[slot] = 1'b1;
        end else if (op != OP_SPARE) begin
            expected_index = {expected_index, (typed ? index : predict_index(op, pos))};
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_index.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (addr == CFG_POINT_COUNT) count_reg = data[PC_W-1:0];
        else if (addr == CFG_END_TOL) tol_reg = data;
        @(posedge aclk);
    endtask

    task automatic load_table(int unsigned n);
        longint v, step_max;
        int unsigned i;
        case ($urandom_range(3))
            0: v = POS_MIN;
            1: v = longint'($urandom_range(2000000)) - 1000000;
            2: v = -longint'($urandom_range(100));
            default: v = longint'($signed($urandom));
        endcase
        case ($urandom_range(3))
            0: step_max = 3;
            1: step_max = 4000;
            2: step_max = 70000;
            default: step_max = 64'hFFFF_FFFF / n;
        endcase
        for (i = 0; i < n; i++) begin
            send_word(OP_WRITE, SLOT_W'(i), POS_W'(v));
            sent++;
            v = v + longint'($urandom_range(32'(step_max)));
            if (v > longint'(POS_MAX)) v = POS_MAX;
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_index.size() == 0) begin
                fails++;
                $display("%0t: unexpected word, expected none, got point_index %0d",
                         $time, m_tdata);
            end else begin
                want = expected_index.pop_front();
                if (m_tdata !== M_TDATA_W'(want)) begin
                    fails++;
                    $display("%0t: point_index mismatch, expected %0d, got %0d",
                             $time, want, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned n, queries, q, slot, phase;
        logic [PC_W-1:0] count_raw;
        longint lo_v, hi_v, val;
        bit full_done, fresh;

        full_done = 1'b0;
        phase     = 0;
        plan = '{
            word_row(OP_WRITE,   0, 32'd1000),
            word_row(OP_LOWER,   0, POS_MIN, 1'b1, 0),
            word_row(OP_LOWER,   0, POS_MAX, 1'b1, 0),
            word_row(OP_NEAREST, 0, 32'd989, 1'b1, 0),
            word_row(OP_NEAREST, 0, 32'd1011, 1'b1, 0),
            word_row(OP_NEAREST, 0, 32'd990, 1'b1, 0),
            word_row(OP_SPARE, 1023, POS_MAX),
            word_row(OP_WRITE,   1, 32'd2000),
            word_row(OP_WRITE,   2, 32'd2000),
            word_row(OP_WRITE,   3, 32'd3000),
            reg_row(CFG_POINT_COUNT, 16'd4),
            reg_row(CFG_END_TOL, 16'd0),
            word_row(OP_LOWER,   0, 32'd1500),
            word_row(OP_LOWER,   0, 32'd2000, 1'b1, 1),
            word_row(OP_NEAREST, 0, 32'd1500),
            word_row(OP_NEAREST, 0, 32'd2500),
            word_row(OP_NEAREST, 0, 32'd3001, 1'b1, 3),
            word_row(OP_NEAREST, 0, 32'd999, 1'b1, 0),
            word_row(OP_LOWER,   0, 32'd3001, 1'b1, 3),
            word_row(OP_WRITE, 1023, POS_MAX),
            word_row(OP_WRITE,   0, POS_MIN),
            word_row(OP_NEAREST, 0, POS_MIN, 1'b1, 0),
            reg_row(CFG_END_TOL, 16'hFFFF),
            word_row(OP_NEAREST, 0, 32'd68535),
            word_row(OP_NEAREST, 0, 32'd68536, 1'b1, 3),
            reg_row(CFG_POINT_COUNT, 16'hF800),
            word_row(OP_LOWER,   0, 32'd5, 1'b1, 0),
            reg_row(CFG_SPARE_A, 16'h1234)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                settle();
                write_reg(plan[i].code, plan[i].value[CFG_DATA_W-1:0]);
            end else begin
                send_word(plan[i].code, plan[i].slot, plan[i].value, plan[i].typed,
                          plan[i].index);
            end
        end

        while (sent < ITEM_TARGET || !full_done) begin
            if (phase == 2 || (full_done && $urandom_range(5) == 0)) begin
                count_raw = ($urandom_range(1) == 0) ? PC_W'(DEPTH)
                                                     : PC_W'($urandom_range(DEPTH, 2047));
            end else begin
                case ($urandom_range(9))
                    0: count_raw = 0;
                    1: count_raw = 1;
                    2: count_raw = 2;
                    8: count_raw = PC_W'($urandom_range(41, 200));
                    default: count_raw = PC_W'($urandom_range(3, 40));
                endcase
            end
            settle();
            if ($urandom_range(1) == 0) write_reg(CFG_POINT_COUNT, {5'($urandom), count_raw});
            case ($urandom_range(4))
                0: write_reg(CFG_END_TOL, 16'd0);
                1: write_reg(CFG_END_TOL, 16'hFFFF);
                2: write_reg(CFG_END_TOL, 16'($urandom_range(1, 20)));
                3: write_reg(CFG_END_TOL, 16'($urandom));
                default: write_reg(CFG_END_TOL, END_TOL_RST);
            endcase
            if (count_reg != count_raw) write_reg(CFG_POINT_COUNT, {5'($urandom), count_raw});
            if ($urandom_range(3) == 0) begin
                write_reg(($urandom_range(1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                          16'($urandom));
            end

            n = used_count();
            fresh = (n <= 200 && $urandom_range(2) == 0);
            for (int i = 0; i < n; i++) begin
                if (!written[i]) fresh = 1'b1;
            end
            if (fresh) load_table(n);
            if (n == DEPTH) full_done = 1'b1;
            if (phase == 1) hold_pending = 1'b1;

            queries = $urandom_range(15, 50);
            for (q = 0; q < queries; q++) begin
                case ($urandom_range(19))
                    0: send_word(OP_SPARE, SLOT_W'($urandom), POS_W'($urandom));
                    1, 2: begin
                        slot = $urandom_range(DEPTH - 1);
                        if (slot > 0 && slot + 1 < n && arc_len[slot-1] <= arc_len[slot+1]
                                && $urandom_range(4) != 0) begin
                            lo_v = arc_len[slot-1];
                            hi_v = arc_len[slot+1];
                            val  = lo_v + longint'($urandom_range(32'(hi_v - lo_v)));
                        end else begin
                            val = longint'($signed($urandom));
                        end
                        send_word(OP_WRITE, SLOT_W'(slot), POS_W'(val));
                        sent++;
                    end
                    3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                        send_word(OP_LOWER, SLOT_W'($urandom), pick_position(n));
                        sent++;
                    end
                    default: begin
                        send_word(OP_NEAREST, SLOT_W'($urandom), pick_position(n));
                        sent++;
                    end
                endcase
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (expected_index.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
